FILE: rtl/lru_timestamp_table_macros.svh
// Assertion macros shared by the LRU timestamp table RTL.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef LRU_TIMESTAMP_TABLE_MACROS_SVH
`define LRU_TIMESTAMP_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LTT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru table check failed");

// Next-cycle implication, checked outside reset.
`define LTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru table check failed");

`endif

FILE: rtl/ltt_pkg.sv
// Shared types and constants for the LRU timestamp table.
// Used by ltt_ctrl, ltt_dp and lru_timestamp_table; depends on nothing.
`default_nettype none

package ltt_pkg;

    localparam int ID_BITS     = 10;
    localparam int TIME_BITS   = 32;
    localparam int COUNT_BITS  = 32;
    localparam int USED_BITS   = 5;
    localparam int ENTRIES_DEF = 16;

    // Command codes; any code with the high bit set clears the table.
    localparam logic [1:0] CMD_TOUCH = 2'd0;
    localparam logic [1:0] CMD_EVICT = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_EVICTED  = 3'd3,
        ST_NONE     = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]            command;
        logic [ID_BITS-1:0]    item_id;
        logic [TIME_BITS-1:0]  now_time;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [ID_BITS-1:0]    result_id;
        logic [COUNT_BITS-1:0] result_count;
        logic [USED_BITS-1:0]  entries_used;
    } rsp_t;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [TIME_BITS-1:0]  stamp;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_SCAN   = 2'd1,
        FSM_LAST   = 2'd2,
        FSM_FINISH = 2'd3
    } fsm_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic read_last;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_clear;
        logic is_evict;
        logic scan_done;
        logic evict_found;
    } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: rtl/lru_timestamp_table.sv
// LRU timestamp table: id lookup with last-use time, use count and eviction.
// Top level; depends on ltt_pkg, ltt_ctrl and ltt_dp.
//
// Usage: drive request (command, item_id, now_time) and raise start. A command
// is taken at a rising edge where start is high and busy is low. Exactly one
// result beat follows: result (status, result_id, result_count, entries_used)
// is valid for the single cycle in which done is high, and the receiver must
// take it then; there is no back-pressure on the result side.
// Timing: the entry memory is scanned one entry per cycle through its single
// read port; a touch or an evict passes through the scan and then a commit step,
// whose result is registered and shown with done. An evict that removes an
// entry adds a step between scan and commit that reads the tail entry that
// refills the slot. A clear leaves the scan state straight for the commit step.
// busy drops in the cycle done rises, so the next command may be accepted then.
// Reset (rst_n low, asynchronous) empties the table and drops busy and done;
// the memory itself is not cleared, since only entries below the fill level
// are ever read.
`default_nettype none

module lru_timestamp_table #(
    parameter int ENTRIES = ltt_pkg::ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ltt_pkg::req_t request,
    output logic               done,
    output ltt_pkg::rsp_t      result
);

    ltt_pkg::ctrl_cmd_t ctl;
    ltt_pkg::ctrl_sts_t sts;

    ltt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    ltt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

endmodule

`default_nettype wire

FILE: rtl/ltt_ctrl.sv
// Sequencer for the LRU timestamp table: scan, tail read and commit steps.
// Depends on ltt_pkg; drives the ltt_dp datapath through ctrl_cmd_t.
`default_nettype none

module ltt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ltt_pkg::ctrl_sts_t sts,
    output ltt_pkg::ctrl_cmd_t      ctl,
    output logic                    busy
);

    ltt_pkg::fsm_t state_reg;
    ltt_pkg::fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ltt_pkg::FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ltt_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = ltt_pkg::FSM_SCAN;
                end
            end
            ltt_pkg::FSM_SCAN:
            begin
                if (sts.is_clear)
                begin
                    state_next = ltt_pkg::FSM_FINISH;
                end
                else if (sts.scan_done)
                begin
                    // A found victim needs the tail entry to fill its slot.
                    if (sts.is_evict && sts.evict_found)
                    begin
                        state_next = ltt_pkg::FSM_LAST;
                    end
                    else
                    begin
                        state_next = ltt_pkg::FSM_FINISH;
                    end
                end
            end
            ltt_pkg::FSM_LAST:
            begin
                state_next = ltt_pkg::FSM_FINISH;
            end
            ltt_pkg::FSM_FINISH:
            begin
                state_next = ltt_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = ltt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        busy          = 1'b1;
        unique case (state_reg)
            ltt_pkg::FSM_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            ltt_pkg::FSM_SCAN:
            begin
                ctl.scan = 1'b1;
            end
            ltt_pkg::FSM_LAST:
            begin
                ctl.read_last = 1'b1;
            end
            ltt_pkg::FSM_FINISH:
            begin
                ctl.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ltt_dp.sv
// Datapath of the LRU timestamp table: entry memory, scan compare and commit.
// Depends on ltt_pkg and lru_timestamp_table_macros.svh; sequenced by ltt_ctrl.
`default_nettype none
`include "lru_timestamp_table_macros.svh"

module ltt_dp #(
    parameter int ENTRIES = ltt_pkg::ENTRIES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ltt_pkg::req_t      request,
    input  wire ltt_pkg::ctrl_cmd_t ctl,
    output ltt_pkg::ctrl_sts_t      sts,
    output ltt_pkg::rsp_t           result,
    output logic                    done
);

    localparam int FW = $clog2(ENTRIES + 1);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Entry memory: one write and one read port, read data registered.
    ltt_pkg::entry_t entry_mem [ENTRIES];
    ltt_pkg::entry_t rd_data_reg;

    ltt_pkg::req_t   req_reg, req_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   scan_idx_reg, scan_idx_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;
    logic            hit_reg, hit_next;
    logic [AW-1:0]   hit_idx_reg, hit_idx_next;
    logic [ltt_pkg::COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next;
    logic            found_reg, found_next;
    logic [ltt_pkg::TIME_BITS-1:0]  best_time_reg, best_time_next;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    logic [ltt_pkg::ID_BITS-1:0]    best_id_reg, best_id_next;
    ltt_pkg::rsp_t   result_reg, result_next;
    logic            done_reg, done_next;

    logic            issue;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [FW-1:0]   fill_m1;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    ltt_pkg::entry_t wr_data;
    logic            is_clear;
    logic            is_evict;
    logic            id_match;
    logic            older;
    logic [ltt_pkg::COUNT_BITS-1:0] cnt_inc;
    logic [31:0]     used_wide;

    assign is_clear = req_reg.command[1];
    assign is_evict = (req_reg.command == ltt_pkg::CMD_EVICT);
    assign fill_m1  = fill_reg - 1'b1;
    assign issue    = ctl.scan && (scan_idx_reg < fill_reg);
    assign rd_en    = issue || ctl.read_last;
    assign rd_addr  = ctl.read_last ? fill_m1[AW-1:0] : scan_idx_reg[AW-1:0];

    assign id_match = rd_vld_reg && !hit_reg && (rd_data_reg.id == req_reg.item_id);
    assign older    = rd_vld_reg && (rd_data_reg.stamp < best_time_reg);
    assign cnt_inc  = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_comb
    begin
        req_next       = req_reg;
        fill_next      = fill_reg;
        scan_idx_next  = scan_idx_reg;
        rd_vld_next    = issue;
        rd_idx_next    = rd_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_cnt_next   = hit_cnt_reg;
        found_next     = found_reg;
        best_time_next = best_time_reg;
        best_idx_next  = best_idx_reg;
        best_id_next   = best_id_reg;
        result_next    = result_reg;
        done_next      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data_reg;
        used_wide      = '0;

        if (ctl.load)
        begin
            req_next       = request;
            scan_idx_next  = '0;
            hit_next       = 1'b0;
            found_next     = 1'b0;
            best_time_next = '1;
        end

        if (issue)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
            rd_idx_next   = rd_addr;
        end

        // Compare stage: works on the entry read in the previous cycle.
        if (id_match)
        begin
            hit_next     = 1'b1;
            hit_idx_next = rd_idx_reg;
            hit_cnt_next = rd_data_reg.count;
        end
        if (older)
        begin
            found_next     = 1'b1;
            best_time_next = rd_data_reg.stamp;
            best_idx_next  = rd_idx_reg;
            best_id_next   = rd_data_reg.id;
        end

        if (ctl.finish)
        begin
            done_next   = 1'b1;
            result_next = '0;
            if (is_clear)
            begin
                fill_next          = '0;
                result_next.status = ltt_pkg::ST_CLEARED;
            end
            else if (is_evict)
            begin
                if (found_reg)
                begin
                    // The tail entry read last cycle moves into the victim slot.
                    wr_en                 = 1'b1;
                    wr_addr               = best_idx_reg;
                    wr_data               = rd_data_reg;
                    fill_next             = fill_m1;
                    result_next.status    = ltt_pkg::ST_EVICTED;
                    result_next.result_id = best_id_reg;
                end
                else
                begin
                    result_next.status = ltt_pkg::ST_NONE;
                end
            end
            else
            begin
                result_next.result_id = req_reg.item_id;
                if (hit_reg)
                begin
                    wr_en                    = 1'b1;
                    wr_addr                  = hit_idx_reg;
                    wr_data.id               = req_reg.item_id;
                    wr_data.stamp            = req_reg.now_time;
                    wr_data.count            = cnt_inc;
                    result_next.status       = ltt_pkg::ST_HIT;
                    result_next.result_count = cnt_inc;
                end
                else if (fill_reg < FW'(ENTRIES))
                begin
                    wr_en                    = 1'b1;
                    wr_addr                  = fill_reg[AW-1:0];
                    wr_data.id               = req_reg.item_id;
                    wr_data.stamp            = req_reg.now_time;
                    wr_data.count            = ltt_pkg::COUNT_BITS'(1);
                    fill_next                = fill_reg + 1'b1;
                    result_next.status       = ltt_pkg::ST_INSERTED;
                    result_next.result_count = ltt_pkg::COUNT_BITS'(1);
                end
                else
                begin
                    result_next.status = ltt_pkg::ST_FULL;
                end
            end
            used_wide                = 32'(fill_next);
            result_next.entries_used = used_wide[ltt_pkg::USED_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            scan_idx_reg <= scan_idx_next;
            rd_vld_reg   <= rd_vld_next;
            hit_reg      <= hit_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rd_idx_reg    <= rd_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_cnt_reg   <= hit_cnt_next;
        best_time_reg <= best_time_next;
        best_idx_reg  <= best_idx_next;
        best_id_reg   <= best_id_next;
        result_reg    <= result_next;
    end

    assign sts.is_clear    = is_clear;
    assign sts.is_evict    = is_evict;
    assign sts.scan_done   = !issue && !rd_vld_reg;
    assign sts.evict_found = found_reg;

    assign result = result_reg;
    assign done   = done_reg;

    `LTT_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= FW'(ENTRIES))
    `LTT_ASSERT_NEXT(a_finish_strobes, ctl.finish, done_reg)
    `LTT_ASSERT_IMPL(a_read_only_in_scan, rd_vld_reg, $past(ctl.scan))
    `LTT_ASSERT_IMPL(a_insert_grows, done_reg && result_reg.status == ltt_pkg::ST_INSERTED, fill_reg == FW'($past(fill_reg) + 1'b1))
    `LTT_ASSERT_IMPL(a_evict_shrinks, done_reg && result_reg.status == ltt_pkg::ST_EVICTED, fill_reg == FW'($past(fill_reg) - 1'b1))

endmodule

`default_nettype wire
